// ===== design/mmcv_pkg.sv =====
// ----------------------------------------------------------------------------
// mmcv_pkg: shared types and constants for the mono MIDI to CV/gate core
// Message codes, controller numbers and the transaction structs.
// ----------------------------------------------------------------------------
`default_nettype none

package mmcv_pkg;

  localparam logic [7:0]  StNoteOn    = 8'h90;
  localparam logic [7:0]  StNoteOff   = 8'h80;
  localparam logic [7:0]  StCtrl      = 8'hB0;
  localparam logic [6:0]  CcSustain   = 7'h40;
  localparam logic [6:0]  CcAllOff    = 7'h7B;
  localparam logic [6:0]  SustainEdge = 7'h3F;
  localparam logic [15:0] TicksReset  = 16'd50;

  localparam logic OpMsg  = 1'b0;
  localparam logic OpTick = 1'b1;

  typedef struct packed {
    logic       op;
    logic [7:0] status;
    logic [6:0] data_one;
    logic [6:0] data_two;
  } item_t;

  typedef struct packed {
    logic       gate;
    logic       trigger;
    logic [6:0] note_level;
    logic [6:0] velocity_level;
  } result_t;

endpackage

`default_nettype wire

// ===== design/mmcv_voice.sv =====
// ----------------------------------------------------------------------------
// mmcv_voice: voice state and its combinational update
// Holds note, flags, gate, trigger, levels and pulse counter; applies one
// transaction per enable and presents the state after that update.
// ----------------------------------------------------------------------------
`default_nettype none

module mmcv_voice (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            en_i,
  input  wire mmcv_pkg::item_t item_i,
  input  wire logic [15:0]     trigger_ticks_i,
  output mmcv_pkg::result_t    res_o
);

  logic [6:0]  held_note_q, held_note_d;
  logic        released_q, released_d;
  logic        sustain_q, sustain_d;
  logic        gate_q, gate_d;
  logic        trig_q, trig_d;
  logic [6:0]  pitch_q, pitch_d;
  logic [6:0]  vel_q, vel_d;
  logic [15:0] cnt_q, cnt_d;

  always_comb begin
    held_note_d = held_note_q;
    released_d  = released_q;
    sustain_d   = sustain_q;
    gate_d      = gate_q;
    trig_d      = trig_q;
    pitch_d     = pitch_q;
    vel_d       = vel_q;
    cnt_d       = cnt_q;
    if (item_i.op == mmcv_pkg::OpTick) begin
      if (trig_q) begin
        if (cnt_q <= 16'd1) begin
          cnt_d  = '0;
          trig_d = 1'b0;
        end else begin
          cnt_d = cnt_q - 16'd1;
        end
      end
    end else begin
      case (item_i.status)
        mmcv_pkg::StNoteOn: begin
          released_d  = 1'b0;
          gate_d      = 1'b1;
          trig_d      = 1'b1;
          cnt_d       = trigger_ticks_i;
          held_note_d = item_i.data_one;
          pitch_d     = item_i.data_one;
          vel_d       = item_i.data_two;
        end
        mmcv_pkg::StNoteOff: begin
          released_d = 1'b1;
          if (item_i.data_one == held_note_q && !sustain_q) begin
            gate_d  = 1'b0;
            pitch_d = '0;
            vel_d   = '0;
          end
        end
        mmcv_pkg::StCtrl: begin
          if (item_i.data_one == mmcv_pkg::CcSustain) begin
            if (item_i.data_two < mmcv_pkg::SustainEdge) begin
              sustain_d = 1'b0;
              if (released_q) begin
                gate_d  = 1'b0;
                pitch_d = '0;
                vel_d   = '0;
              end
            end else begin
              sustain_d = 1'b1;
            end
          end else if (item_i.data_one == mmcv_pkg::CcAllOff) begin
            sustain_d  = 1'b0;
            released_d = 1'b1;
            gate_d     = 1'b0;
            pitch_d    = '0;
            vel_d      = '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_note_q <= '0;
      released_q  <= 1'b0;
      sustain_q   <= 1'b0;
      gate_q      <= 1'b0;
      trig_q      <= 1'b0;
      pitch_q     <= '0;
      vel_q       <= '0;
      cnt_q       <= '0;
    end else if (en_i) begin
      held_note_q <= held_note_d;
      released_q  <= released_d;
      sustain_q   <= sustain_d;
      gate_q      <= gate_d;
      trig_q      <= trig_d;
      pitch_q     <= pitch_d;
      vel_q       <= vel_d;
      cnt_q       <= cnt_d;
    end
  end

  assign res_o.gate           = gate_d;
  assign res_o.trigger        = trig_d;
  assign res_o.note_level     = pitch_d;
  assign res_o.velocity_level = vel_d;

`ifndef ASSERT_OFF
  a_gate_low_levels_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !gate_q |-> (pitch_q == 7'd0 && vel_q == 7'd0))
    else $error("gate low with nonzero levels");
  a_trig_off_cnt_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !trig_q |-> (cnt_q == 16'd0))
    else $error("pulse counter running without trigger");
  a_hold_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en_i |=> ($stable(gate_q) && $stable(trig_q) && $stable(cnt_q)))
    else $error("voice state changed without a transaction");
`endif

endmodule

`default_nettype wire

// ===== design/midi_mono_note_to_cv_gate_core.sv =====
// ----------------------------------------------------------------------------
// midi_mono_note_to_cv_gate_core: monophonic MIDI message to CV/gate core
// Applies note-on/off, sustain and all-notes-off messages and time ticks to
// one voice, and returns gate, trigger and the note and velocity levels.
//
//   channel  dir  handshake             payload
//   in       in   in_valid_i/in_stall_o op, status, data_one, data_two
//   out      out  out_valid_o/out_stall_i gate, trigger, note/velocity level
//   cfg      in   cfg_we_i              cfg_wdata_i (trigger_ticks)
//
// One transaction per cycle sustained while out_stall_i is low; each passes
// the input register, then the voice update into the result register.
// Reset clears voice state and loads trigger_ticks with 50.
// Output stall holds the result register; the input register holds behind it.
// ----------------------------------------------------------------------------
`default_nettype none

module midi_mono_note_to_cv_gate_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [15:0] cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        op_i,
  input  wire logic [7:0]  status_i,
  input  wire logic [6:0]  data_one_i,
  input  wire logic [6:0]  data_two_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             gate_o,
  output logic             trigger_o,
  output logic [6:0]       note_level_o,
  output logic [6:0]       velocity_level_o
);

  logic [15:0]       ticks_q;
  logic              s1_valid_q;
  mmcv_pkg::item_t   s1_item_q;
  logic              out_valid_q;
  mmcv_pkg::result_t out_res_q;
  mmcv_pkg::result_t res;
  logic              out_free;
  logic              advance;
  logic              in_take;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign advance    = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ticks_q <= mmcv_pkg::TicksReset;
    end else if (cfg_we_i) begin
      ticks_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_take) begin
      s1_valid_q <= 1'b1;
    end else if (advance) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_item_q <= '{op: op_i, status: status_i, data_one: data_one_i,
                     data_two: data_two_i};
    end
  end

  mmcv_voice u_voice (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .en_i            (advance),
    .item_i          (s1_item_q),
    .trigger_ticks_i (ticks_q),
    .res_o           (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_res_q <= res;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign gate_o           = out_res_q.gate;
  assign trigger_o        = out_res_q.trigger;
  assign note_level_o     = out_res_q.note_level;
  assign velocity_level_o = out_res_q.velocity_level;

`ifndef ASSERT_OFF
  a_stall_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && out_valid_q))
    else $error("input stalled with free pipeline");
  a_s1_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !out_free) |=> (s1_valid_q && $stable(s1_item_q)))
    else $error("input register lost a waiting transaction");
  a_result_low_gate: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_res_q.gate) |->
      (out_res_q.note_level == 7'd0 && out_res_q.velocity_level == 7'd0))
    else $error("result shows levels with gate low");
`endif

endmodule

`default_nettype wire

// ===== tb/midi_mono_note_to_cv_gate_core_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// midi_mono_note_to_cv_gate_core_test: self-checking bench for the mono core
// Walks a short table of note, controller and tick transactions, then runs
// random streams, some with arbitrary status bytes, under several trigger
// lengths. Each result is checked field by field against a typed table entry
// or the in-bench voice model. Both channels idle at random unless steady.
// ----------------------------------------------------------------------------

module midi_mono_note_to_cv_gate_core_test;

  localparam int unsigned PhaseItems = 205;
  localparam int unsigned IdleLimit  = 2000;
  localparam bit          Typed      = 1'b1;
  localparam bit          Predicted  = 1'b0;

  typedef struct packed {
    mmcv_pkg::item_t   it;
    logic              typed;
    mmcv_pkg::result_t want;
  } row_t;

  logic        clk_i            = 1'b0;
  logic        rst_ni           = 1'b0;
  logic        cfg_we_i         = 1'b0;
  logic [15:0] cfg_wdata_i      = '0;
  logic        in_valid_i       = 1'b0;
  logic        in_stall_o;
  logic        op_i             = 1'b0;
  logic [7:0]  status_i         = '0;
  logic [6:0]  data_one_i       = '0;
  logic [6:0]  data_two_i       = '0;
  logic        out_valid_o;
  logic        out_stall_i      = 1'b0;
  logic        gate_o;
  logic        trigger_o;
  logic [6:0]  note_level_o;
  logic [6:0]  velocity_level_o;

  midi_mono_note_to_cv_gate_core u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .op_i             (op_i),
    .status_i         (status_i),
    .data_one_i       (data_one_i),
    .data_two_i       (data_two_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .gate_o           (gate_o),
    .trigger_o        (trigger_o),
    .note_level_o     (note_level_o),
    .velocity_level_o (velocity_level_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // voice model state
  logic [15:0] pulse_len   = mmcv_pkg::TicksReset;
  logic [6:0]  v_held      = '0;
  logic        v_released  = 1'b0;
  logic        v_sustain   = 1'b0;
  logic        v_gate      = 1'b0;
  logic        v_trigger   = 1'b0;
  logic [6:0]  v_pitch     = '0;
  logic [6:0]  v_vel       = '0;
  logic [15:0] v_countdown = '0;

  mmcv_pkg::result_t levels_due [$];
  int unsigned errors       = 0;
  int unsigned items_sent   = 0;
  int unsigned results_seen = 0;
  int unsigned idle_cycles  = 0;
  bit          steady       = 1'b0;

  logic [15:0] pulse_plan [7] = '{16'd1, 16'd2, 16'd0, 16'hFFFF, 16'd3, 16'd7, 16'd25};

  row_t script [19] = '{
    {mmcv_pkg::OpTick, 8'h00, 7'd0, 7'd0, Typed, 1'b0, 1'b0, 7'd0, 7'd0},
    {mmcv_pkg::OpMsg, mmcv_pkg::StNoteOff, 7'd0, 7'd0, Typed, 1'b0, 1'b0, 7'd0, 7'd0},
    {mmcv_pkg::OpMsg, mmcv_pkg::StNoteOn, 7'd127, 7'd127, Typed,
     1'b1, 1'b1, 7'd127, 7'd127},
    {mmcv_pkg::OpTick, 8'hFF, 7'd127, 7'd127, Predicted, 16'h0},
    {mmcv_pkg::OpMsg, mmcv_pkg::StNoteOff, 7'd0, 7'd64, Predicted, 16'h0},
    {mmcv_pkg::OpMsg, mmcv_pkg::StNoteOff, 7'd127, 7'd0, Typed,
     1'b0, 1'b1, 7'd0, 7'd0},
    {mmcv_pkg::OpMsg, mmcv_pkg::StNoteOn, 7'd0, 7'd0, Typed, 1'b1, 1'b1, 7'd0, 7'd0},
    {mmcv_pkg::OpMsg, mmcv_pkg::StCtrl, mmcv_pkg::CcSustain, mmcv_pkg::SustainEdge,
     Predicted, 16'h0},
    {mmcv_pkg::OpMsg, mmcv_pkg::StNoteOff, 7'd0, 7'd0, Predicted, 16'h0},
    {mmcv_pkg::OpMsg, mmcv_pkg::StCtrl, mmcv_pkg::CcSustain,
     mmcv_pkg::SustainEdge - 7'd1, Typed, 1'b0, 1'b1, 7'd0, 7'd0},
    {mmcv_pkg::OpMsg, mmcv_pkg::StNoteOn, 7'd60, 7'd100, Predicted, 16'h0},
    {mmcv_pkg::OpMsg, mmcv_pkg::StCtrl, mmcv_pkg::CcSustain, 7'd127, Predicted, 16'h0},
    {mmcv_pkg::OpMsg, mmcv_pkg::StCtrl, mmcv_pkg::CcAllOff, 7'd0, Typed,
     1'b0, 1'b1, 7'd0, 7'd0},
    {mmcv_pkg::OpMsg, mmcv_pkg::StNoteOn, 7'd64, 7'd1, Predicted, 16'h0},
    {mmcv_pkg::OpMsg, 8'hFF, 7'd127, 7'd127, Predicted, 16'h0},
    {mmcv_pkg::OpMsg, 8'h91, 7'd5, 7'd5, Predicted, 16'h0},
    {mmcv_pkg::OpMsg, mmcv_pkg::StCtrl, 7'h41, 7'd0, Predicted, 16'h0},
    {mmcv_pkg::OpTick, mmcv_pkg::StNoteOff, 7'd64, 7'd0, Predicted, 16'h0},
    {mmcv_pkg::OpMsg, mmcv_pkg::StCtrl, mmcv_pkg::CcSustain, 7'd0, Predicted, 16'h0}
  };

  function automatic void drop_note(input logic [6:0] n);
    v_released = 1'b1;
    if (n == v_held && !v_sustain) begin
      v_gate  = 1'b0;
      v_pitch = '0;
      v_vel   = '0;
    end
  endfunction

  function automatic mmcv_pkg::result_t voice_apply(input mmcv_pkg::item_t it);
    if (it.op == mmcv_pkg::OpTick) begin
      if (v_trigger) begin
        if (v_countdown <= 16'd1) begin
          v_countdown = '0;
          v_trigger   = 1'b0;
        end else begin
          v_countdown = v_countdown - 16'd1;
        end
      end
    end else if (it.status == mmcv_pkg::StNoteOn) begin
      v_released  = 1'b0;
      v_gate      = 1'b1;
      v_trigger   = 1'b1;
      v_countdown = pulse_len;
      v_held      = it.data_one;
      v_pitch     = it.data_one;
      v_vel       = it.data_two;
    end else if (it.status == mmcv_pkg::StNoteOff) begin
      drop_note(it.data_one);
    end else if (it.status == mmcv_pkg::StCtrl) begin
      if (it.data_one == mmcv_pkg::CcSustain) begin
        if (it.data_two < mmcv_pkg::SustainEdge) begin
          v_sustain = 1'b0;
          if (v_released) drop_note(v_held);
        end else begin
          v_sustain = 1'b1;
        end
      end else if (it.data_one == mmcv_pkg::CcAllOff) begin
        v_sustain  = 1'b0;
        v_released = 1'b1;
        drop_note(v_held);
      end
    end
    return {v_gate, v_trigger, v_pitch, v_vel};
  endfunction

  function automatic bit acts(input mmcv_pkg::item_t it);
    return it.op == mmcv_pkg::OpTick || it.status == mmcv_pkg::StNoteOn ||
           it.status == mmcv_pkg::StNoteOff || it.status == mmcv_pkg::StCtrl;
  endfunction

  function automatic mmcv_pkg::item_t pick_item();
    mmcv_pkg::item_t it;
    int unsigned     r;
    r           = $urandom_range(0, 99);
    it.op       = mmcv_pkg::OpMsg;
    it.status   = mmcv_pkg::StNoteOn;
    it.data_one = 7'($urandom_range(0, 127));
    it.data_two = 7'($urandom_range(0, 127));
    if (r < 30) begin
    end else if (r < 50) begin
      it.status = mmcv_pkg::StNoteOff;
      if ($urandom_range(0, 3) != 0) it.data_one = v_held;
    end else if (r < 78) begin
      it.op     = mmcv_pkg::OpTick;
      it.status = 8'($urandom_range(0, 255));
    end else if (r < 88) begin
      it.status   = mmcv_pkg::StCtrl;
      it.data_one = mmcv_pkg::CcSustain;
      if ($urandom_range(0, 1) != 0)
        it.data_two = 7'(mmcv_pkg::SustainEdge - 7'd1 + $urandom_range(0, 2));
    end else if (r < 91) begin
      it.status   = mmcv_pkg::StCtrl;
      it.data_one = mmcv_pkg::CcAllOff;
    end else begin
      it.status = $urandom_range(0, 1) != 0 ? mmcv_pkg::StCtrl : 8'($urandom_range(0, 255));
    end
    return it;
  endfunction

  task automatic flag_mismatch(input string what, input int got, input int want);
    $display("MISMATCH %s: got %0d, expected %0d (result %0d, t=%0t)",
             what, got, want, results_seen, $realtime);
    errors++;
  endtask

  task automatic push_item(input mmcv_pkg::item_t it, input bit typed,
                           input mmcv_pkg::result_t want);
    mmcv_pkg::result_t pred;
    while (!steady && $urandom_range(0, 99) < 17) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i       <= it.op;
    status_i   <= it.status;
    data_one_i <= it.data_one;
    data_two_i <= it.data_two;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pred = voice_apply(it);
    levels_due.push_back(typed ? want : pred);
    items_sent++;
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (levels_due.size() != 0) @(posedge clk_i);
  endtask

  task automatic load_pulse_len(input logic [15:0] len);
    settle();
    repeat (4) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= len;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    pulse_len    = len;
  endtask

  always @(posedge clk_i) begin : sink
    mmcv_pkg::result_t got;
    mmcv_pkg::result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = {gate_o, trigger_o, note_level_o, velocity_level_o};
      if (levels_due.size() == 0) begin
        flag_mismatch("result with nothing pending", int'(got), 0);
      end else begin
        want = levels_due.pop_front();
        if (got.gate != want.gate)
          flag_mismatch("gate", int'(got.gate), int'(want.gate));
        if (got.trigger != want.trigger)
          flag_mismatch("trigger", int'(got.trigger), int'(want.trigger));
        if (got.note_level != want.note_level)
          flag_mismatch("note_level", int'(got.note_level), int'(want.note_level));
        if (got.velocity_level != want.velocity_level)
          flag_mismatch("velocity_level", int'(got.velocity_level),
                        int'(want.velocity_level));
      end
      results_seen++;
    end
    out_stall_i <= !steady && ($urandom_range(0, 99) < 17);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
        $display("Timeout: no transaction for %0d cycles", idle_cycles);
        $display("DONE: errors detected");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin : stimulus
    mmcv_pkg::item_t it;
    int unsigned     cnt;
    pulse_plan[5] = 16'($urandom_range(4, 12));
    pulse_plan[6] = 16'($urandom_range(13, 60));
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (script[i]) push_item(script[i].it, script[i].typed, script[i].want);
    foreach (pulse_plan[p]) begin
      load_pulse_len(pulse_plan[p]);
      steady = (p == 3);
      cnt    = 0;
      while (cnt < PhaseItems) begin
        it = pick_item();
        if (p == 1 && cnt == PhaseItems / 2) settle();
        push_item(it, Predicted, '0);
        if (acts(it)) cnt++;
      end
    end
    settle();
    repeat (4) @(posedge clk_i);
    $display("Covered %0d transactions over %0d trigger lengths (0 to 65535),",
             items_sent, $size(pulse_plan) + 1);
    $display("%0d results checked", results_seen);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/mmcv_pkg.sv
design/mmcv_voice.sv
design/midi_mono_note_to_cv_gate_core.sv
tb/midi_mono_note_to_cv_gate_core_test.sv
